### rtl/trle_pkg.sv
`default_nettype none

package trle_pkg;

  // Pixel and run widths
  localparam int PIX_W      = 8;
  localparam int LEN_W      = 7;
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = WORD_BYTES * PIX_W;
  localparam int CNT_W      = 4;
  localparam int SLOT_W     = 3;

  // Run limit and literal store depth
  localparam logic [LEN_W-1:0] MAX_RUN     = 7'd127;
  localparam int               STORE_DEPTH = 127;

  // Run header flags and line terminator
  localparam logic [PIX_W-1:0] TRANSPARENT_FLAG = 8'h80;
  localparam logic [PIX_W-1:0] OPAQUE_FLAG      = 8'h00;
  localparam logic [PIX_W-1:0] LINE_TERM        = 8'h00;

  // Byte sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_AHDR = 6'b000010,
    ST_ALIT = 6'b000100,
    ST_BHDR = 6'b001000,
    ST_BLIT = 6'b010000,
    ST_ZERO = 6'b100000
  } seq_state_t;

  // Header byte of a flushed run
  function automatic logic [PIX_W-1:0] run_header(input logic opq, input logic [LEN_W-1:0] len);
    logic [PIX_W-1:0] hdr;
    hdr = {1'b0, len};
    run_header = hdr | (opq ? OPAQUE_FLAG : TRANSPARENT_FLAG);
  endfunction

endpackage

`default_nettype wire

### rtl/trle_ram.sv
`default_nettype none

module trle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 127
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/transparent_run_length_encoder.sv
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   in_pixel[7:0], in_line_end
// out_      output     out_valid / out_ready out_bytes[63:0], out_byte_count[3:0],
//                                            out_line_done, out_item_last
// cfg_      input      cfg_wr_en             cfg_transparent_index[7:0]
//
// An item that only extends a run leaves the sequencer idle; the next item can follow at once.
// An item that flushes bytes keeps in_ready low until the sequencer is idle; the sequencer
// emits one byte per cycle unless held, literals coming from the store's single read port.
// Reset (rst_n, synchronous) clears the run state and the sequencer; the store is not cleared.
// An output word that is not taken holds the sequencer, once the next word is due, until out_ready is high.
`default_nettype none

module transparent_run_length_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_pixel,
  input  wire logic        in_line_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_bytes,
  output logic [3:0]       out_byte_count,
  output logic             out_line_done,
  output logic             out_item_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_transparent_index
);

  localparam int PW = trle_pkg::PIX_W;
  localparam int LW = trle_pkg::LEN_W;
  localparam int WW = trle_pkg::WORD_W;
  localparam int CW = trle_pkg::CNT_W;
  localparam int SW = trle_pkg::SLOT_W;

  // Configuration and run state
  logic [PW-1:0] tidx_r;
  logic          run_opq_r, run_opq_nxt;
  logic [LW-1:0] run_len_r, run_len_nxt;

  // Flush plan of the accepted transaction
  logic          a_opq_r, a_opq_nxt;
  logic [LW-1:0] a_len_r, a_len_nxt;
  logic          b_vld_r, b_vld_nxt, b_opq_r, b_opq_nxt;
  logic [LW-1:0] b_len_r, b_len_nxt;
  logic          z_r, z_nxt;

  // Sequencer
  trle_pkg::seq_state_t state_r, state_nxt;
  logic [LW-1:0] idx_r, idx_nxt;

  // Byte stage between sequencer and packer
  logic          byte_vld_r, byte_vld_nxt;
  logic          byte_mem_r, byte_mem_nxt;
  logic [PW-1:0] byte_r, byte_nxt;
  logic          byte_last_r, byte_last_nxt;
  logic          byte_line_r, byte_line_nxt;

  // Packer and output word
  logic [WW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] acc_cnt_r, acc_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [WW-1:0] out_bytes_r, out_bytes_nxt;
  logic [CW-1:0] out_cnt_r, out_cnt_nxt;
  logic          out_line_r, out_line_nxt;
  logic          out_last_r, out_last_nxt;

  // Store ports
  logic          ram_we, ram_re;
  logic [LW-1:0] ram_waddr, ram_raddr;
  logic [PW-1:0] ram_rdata;

  logic          in_acc, opq, flush_a, flush_b;
  logic [LW-1:0] len_base, len_new;
  logic          emit_vld, emit_mem, emit_last;
  logic [PW-1:0] emit_byte;
  logic          push, advance;
  logic [PW-1:0] byte_val;
  logic [WW-1:0] acc_add;

  trle_ram #(
    .WIDTH (PW),
    .DEPTH (trle_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_pixel),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Classify the pixel and plan the flushes
  assign in_ready = (state_r == trle_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign opq      = (in_pixel != tidx_r);
  assign flush_a  = (run_len_r != '0) && (run_opq_r != opq);
  assign len_base = flush_a ? '0 : run_len_r;
  assign len_new  = len_base + LW'(1);
  assign flush_b  = (len_new == trle_pkg::MAX_RUN) || in_line_end;

  assign ram_we    = in_acc && opq;
  assign ram_waddr = len_base;

  // Packer hold: a word is due but the output register is still occupied
  assign push    = byte_vld_r && ((acc_cnt_r == SW'(trle_pkg::WORD_BYTES - 1)) || byte_last_r);
  assign advance = !(push && out_valid_r && !out_ready);

  // Run state update and plan load
  always_comb begin
    run_opq_nxt = run_opq_r;
    run_len_nxt = run_len_r;
    a_opq_nxt   = a_opq_r;
    a_len_nxt   = a_len_r;
    b_vld_nxt   = b_vld_r;
    b_opq_nxt   = b_opq_r;
    b_len_nxt   = b_len_r;
    z_nxt       = z_r;
    if (in_acc) begin
      run_opq_nxt = opq;
      run_len_nxt = flush_b ? '0 : len_new;
      a_opq_nxt   = run_opq_r;
      a_len_nxt   = run_len_r;
      b_vld_nxt   = flush_b;
      b_opq_nxt   = opq;
      b_len_nxt   = len_new;
      z_nxt       = in_line_end;
    end
  end

  // Byte sequencer: one byte per cycle while the packer does not hold it, literals read from the store
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    emit_vld  = 1'b0;
    emit_mem  = 1'b0;
    emit_last = 1'b0;
    emit_byte = trle_pkg::LINE_TERM;
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    case (state_r)
      trle_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (flush_a) begin
            state_nxt = trle_pkg::ST_AHDR;
          end else if (flush_b) begin
            state_nxt = trle_pkg::ST_BHDR;
          end
        end
      end
      trle_pkg::ST_AHDR: begin
        if (advance) begin
          emit_vld  = 1'b1;
          emit_byte = trle_pkg::run_header(a_opq_r, a_len_r);
          idx_nxt   = '0;
          if (a_opq_r) begin
            state_nxt = trle_pkg::ST_ALIT;
          end else begin
            emit_last = !b_vld_r && !z_r;
            state_nxt = b_vld_r ? trle_pkg::ST_BHDR :
                        z_r     ? trle_pkg::ST_ZERO : trle_pkg::ST_IDLE;
          end
        end
      end
      trle_pkg::ST_ALIT: begin
        if (advance) begin
          emit_vld = 1'b1;
          emit_mem = 1'b1;
          ram_re   = 1'b1;
          idx_nxt  = idx_r + LW'(1);
          if (idx_r == a_len_r - LW'(1)) begin
            emit_last = !b_vld_r && !z_r;
            state_nxt = b_vld_r ? trle_pkg::ST_BHDR :
                        z_r     ? trle_pkg::ST_ZERO : trle_pkg::ST_IDLE;
          end
        end
      end
      trle_pkg::ST_BHDR: begin
        if (advance) begin
          emit_vld  = 1'b1;
          emit_byte = trle_pkg::run_header(b_opq_r, b_len_r);
          idx_nxt   = '0;
          if (b_opq_r) begin
            state_nxt = trle_pkg::ST_BLIT;
          end else begin
            emit_last = !z_r;
            state_nxt = z_r ? trle_pkg::ST_ZERO : trle_pkg::ST_IDLE;
          end
        end
      end
      trle_pkg::ST_BLIT: begin
        if (advance) begin
          emit_vld = 1'b1;
          emit_mem = 1'b1;
          ram_re   = 1'b1;
          idx_nxt  = idx_r + LW'(1);
          if (idx_r == b_len_r - LW'(1)) begin
            emit_last = !z_r;
            state_nxt = z_r ? trle_pkg::ST_ZERO : trle_pkg::ST_IDLE;
          end
        end
      end
      trle_pkg::ST_ZERO: begin
        if (advance) begin
          emit_vld  = 1'b1;
          emit_byte = trle_pkg::LINE_TERM;
          emit_last = 1'b1;
          state_nxt = trle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = trle_pkg::ST_IDLE;
      end
    endcase
  end

  // Byte stage: advance or hold
  always_comb begin
    byte_vld_nxt  = byte_vld_r;
    byte_mem_nxt  = byte_mem_r;
    byte_nxt      = byte_r;
    byte_last_nxt = byte_last_r;
    byte_line_nxt = byte_line_r;
    if (advance) begin
      byte_vld_nxt  = emit_vld;
      byte_mem_nxt  = emit_mem;
      byte_nxt      = emit_byte;
      byte_last_nxt = emit_last;
      byte_line_nxt = z_r;
    end
  end

  // Packer: place the byte in its lane, push a word when full or at item end
  assign byte_val = byte_mem_r ? ram_rdata : byte_r;
  assign acc_add  = acc_r | ({{(WW-PW){1'b0}}, byte_val} << {acc_cnt_r, 3'b000});

  always_comb begin
    acc_nxt       = acc_r;
    acc_cnt_nxt   = acc_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_bytes_nxt = out_bytes_r;
    out_cnt_nxt   = out_cnt_r;
    out_line_nxt  = out_line_r;
    out_last_nxt  = out_last_r;
    if (byte_vld_r && advance) begin
      if (push) begin
        acc_nxt       = '0;
        acc_cnt_nxt   = '0;
        out_valid_nxt = 1'b1;
        out_bytes_nxt = acc_add;
        out_cnt_nxt   = {1'b0, acc_cnt_r} + CW'(1);
        out_line_nxt  = byte_last_r && byte_line_r;
        out_last_nxt  = byte_last_r;
      end else begin
        acc_nxt     = acc_add;
        acc_cnt_nxt = acc_cnt_r + SW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tidx_r      <= '0;
      run_opq_r   <= 1'b0;
      run_len_r   <= '0;
      b_vld_r     <= 1'b0;
      z_r         <= 1'b0;
      state_r     <= trle_pkg::ST_IDLE;
      byte_vld_r  <= 1'b0;
      acc_r       <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tidx_r <= cfg_transparent_index;
      end
      run_opq_r   <= run_opq_nxt;
      run_len_r   <= run_len_nxt;
      b_vld_r     <= b_vld_nxt;
      z_r         <= z_nxt;
      state_r     <= state_nxt;
      byte_vld_r  <= byte_vld_nxt;
      acc_r       <= acc_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_opq_r     <= a_opq_nxt;
    a_len_r     <= a_len_nxt;
    b_opq_r     <= b_opq_nxt;
    b_len_r     <= b_len_nxt;
    idx_r       <= idx_nxt;
    byte_mem_r  <= byte_mem_nxt;
    byte_r      <= byte_nxt;
    byte_last_r <= byte_last_nxt;
    byte_line_r <= byte_line_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_line_r  <= out_line_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_bytes      = out_bytes_r;
  assign out_byte_count = out_cnt_r;
  assign out_line_done  = out_line_r;
  assign out_item_last  = out_last_r;

`ifndef SYNTH
  // A run never rests at the limit: it is flushed in the step that reaches it
  a_run_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    run_len_r != trle_pkg::MAX_RUN)
    else $error("run length reached the limit without a flush");

  // The end of a line always leaves an empty run
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_line_end |=> run_len_r == '0)
    else $error("run not cleared at end of line");

  // The terminating word is always the last word of its transaction
  a_line_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_line_r |-> out_last_r)
    else $error("line_done without item_last");

  // A held byte is never dropped
  a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld_r && !advance |=> byte_vld_r && $stable(byte_r) && $stable(acc_cnt_r))
    else $error("pending byte lost during stall");

  // A word carries between one and eight bytes
  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r != '0) && (out_cnt_r <= CW'(trle_pkg::WORD_BYTES)))
    else $error("bad byte count on output word");
`endif

endmodule

`default_nettype wire
